// ===== rtl/ptm_pkg.sv =====
package ptm_pkg;

  localparam int unsigned DIR_ENTRIES = 1024;
  localparam int unsigned DIR_IDX_W   = 10;
  localparam int unsigned TBL_ENTRIES = 1024;
  localparam int unsigned TBL_IDX_W   = 10;
  localparam int unsigned PAGE_W      = 12;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_MAP    = 2'd0,
    OP_UNMAP  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic {
    TA_LINKED,
    TA_WALK
  } taddr_sel_e;

  typedef enum logic [1:0] {
    TD_ENTRY,
    TD_ZERO,
    TD_WALK
  } tdata_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_FULL,
    RES_LOOKUP,
    RES_HELD
  } res_sel_e;

  typedef struct packed {
    logic       capture;
    logic       dir_wr;
    logic       dir_clr;
    logic       alloc;
    logic       tbl_wr;
    taddr_sel_e taddr_sel;
    tdata_sel_e tdata_sel;
    logic       cnt_clr;
    logic       cnt_inc;
    res_sel_e   res_sel;
    logic       load_out;
    logic       cap_res;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            link_zero;
    logic            pool_full;
    logic            cnt_last;
    logic            out_free;
  } ctrl_status_t;

endpackage

// ===== rtl/ptm_ram.sv =====
module ptm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ptm_datapath.sv =====
module ptm_datapath import ptm_pkg::*; #(
  parameter int unsigned NUM_TABLES = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic                   out_ready_i,
  input  ctrl_cmd_t              cmd_i,
  output ctrl_status_t           status_o,
  output logic                   out_valid_o,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  localparam int unsigned LINK_W    = $clog2(NUM_TABLES + 1);
  localparam int unsigned TNUM_W    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned TADDR_W   = TNUM_W + TBL_IDX_W;
  localparam int unsigned TBL_DEPTH = ((NUM_TABLES > 1) ? NUM_TABLES : 2) * TBL_ENTRIES;
  localparam int unsigned FRAME_W   = ADDR_W - PAGE_W;

  logic [OP_W-1:0]      op_q;
  logic [ADDR_W-1:0]    va_q;
  logic [FRAME_W-1:0]   frame_in_q;
  logic [PAGE_W-1:0]    flags_q;
  logic [LINK_W-1:0]    next_free_q, next_free_d;
  logic [TNUM_W-1:0]    base_q;
  logic [TBL_IDX_W-1:0] cnt_q, cnt_d;

  logic                 held_hit_q, held_full_q;
  logic [ADDR_W-1:0]    held_frame_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q, out_full_q;
  logic [ADDR_W-1:0]    out_frame_q;

  logic [ADDR_W-1:0]    in_va;
  logic [DIR_IDX_W-1:0] dir_waddr;
  logic [LINK_W-1:0]    dir_wdata, dir_rdata, link_m1;
  logic [TADDR_W-1:0]   tbl_addr;
  logic [ADDR_W-1:0]    tbl_wdata, tbl_rdata, entry;
  logic [TBL_IDX_W-1:0] tbl_idx;
  logic                 res_hit, res_full;
  logic [ADDR_W-1:0]    res_frame;

  assign in_va   = in_data_i[OP_W +: ADDR_W];
  assign tbl_idx = va_q[PAGE_W +: TBL_IDX_W];
  assign entry   = {frame_in_q, flags_q};
  assign link_m1 = dir_rdata - LINK_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= in_data_i[OP_W-1:0];
      va_q       <= in_va;
      frame_in_q <= in_data_i[OP_W+ADDR_W+PAGE_W +: FRAME_W];
      flags_q    <= in_data_i[OP_W+2*ADDR_W +: PAGE_W];
    end
    if (cmd_i.alloc) begin
      base_q <= next_free_q[TNUM_W-1:0];
    end
    if (cmd_i.cap_res) begin
      held_hit_q   <= res_hit;
      held_frame_q <= res_frame;
      held_full_q  <= res_full;
    end
    if (cmd_i.load_out) begin
      out_hit_q   <= res_hit;
      out_frame_q <= res_frame;
      out_full_q  <= res_full;
    end
  end

  always_comb begin
    next_free_d = next_free_q;
    if (cmd_i.alloc) begin
      next_free_d = next_free_q + LINK_W'(1);
    end
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + TBL_IDX_W'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      next_free_q <= next_free_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // directory: zero means no table, otherwise table number plus one
  assign dir_waddr = cmd_i.dir_clr ? cnt_q : va_q[PAGE_W+TBL_IDX_W +: DIR_IDX_W];
  assign dir_wdata = cmd_i.dir_clr ? '0 : next_free_q + LINK_W'(1);

  ptm_ram #(
    .WIDTH(LINK_W),
    .DEPTH(DIR_ENTRIES)
  ) u_dir_ram (
    .clk_i  (clk_i),
    .wr_en_i(cmd_i.dir_wr),
    .waddr_i(dir_waddr),
    .wdata_i(dir_wdata),
    .raddr_i(in_va[PAGE_W+TBL_IDX_W +: DIR_IDX_W]),
    .rdata_o(dir_rdata)
  );

  always_comb begin
    unique case (cmd_i.taddr_sel)
      TA_LINKED: tbl_addr = {link_m1[TNUM_W-1:0], tbl_idx};
      TA_WALK:   tbl_addr = {base_q, cnt_q};
      default:   tbl_addr = {base_q, cnt_q};
    endcase
    unique case (cmd_i.tdata_sel)
      TD_ENTRY: tbl_wdata = entry;
      TD_ZERO:  tbl_wdata = '0;
      TD_WALK:  tbl_wdata = (cnt_q == tbl_idx) ? entry : '0;
      default:  tbl_wdata = '0;
    endcase
  end

  ptm_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(TBL_DEPTH)
  ) u_tbl_ram (
    .clk_i  (clk_i),
    .wr_en_i(cmd_i.tbl_wr),
    .waddr_i(tbl_addr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_addr),
    .rdata_o(tbl_rdata)
  );

  always_comb begin
    res_hit   = 1'b0;
    res_frame = '0;
    res_full  = 1'b0;
    unique case (cmd_i.res_sel)
      RES_ZERO: ;
      RES_FULL: res_full = 1'b1;
      RES_LOOKUP: begin
        res_hit   = (tbl_rdata != '0);
        res_frame = {tbl_rdata[ADDR_W-1:PAGE_W], PAGE_W'(0)};
      end
      RES_HELD: begin
        res_hit   = held_hit_q;
        res_frame = held_frame_q;
        res_full  = held_full_q;
      end
      default: ;
    endcase
  end

  assign status_o.op        = op_q;
  assign status_o.link_zero = (dir_rdata == '0);
  assign status_o.pool_full = (next_free_q == LINK_W'(NUM_TABLES));
  assign status_o.cnt_last  = (cnt_q == TBL_IDX_W'(TBL_ENTRIES - 1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {(OUT_TDATA_W - ADDR_W - 2)'(0), out_full_q, out_frame_q, out_hit_q};

endmodule

// ===== rtl/ptm_ctrl.sv =====
module ptm_ctrl import ptm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR,
    ST_ZERO,
    ST_TBL_RD,
    ST_RESP
  } state_e;

  state_e   state_q, state_d;
  logic     fin;
  res_sel_e fin_sel;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    fin     = 1'b0;
    fin_sel = RES_ZERO;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.dir_wr  = 1'b1;
        cmd_o.dir_clr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DIR;
        end
      end
      ST_DIR: begin
        cmd_o.taddr_sel = TA_LINKED;
        unique case (op_e'(status_i.op))
          OP_MAP: begin
            if (!status_i.link_zero) begin
              cmd_o.tbl_wr    = 1'b1;
              cmd_o.tdata_sel = TD_ENTRY;
              fin             = 1'b1;
            end else if (status_i.pool_full) begin
              fin     = 1'b1;
              fin_sel = RES_FULL;
            end else begin
              cmd_o.alloc   = 1'b1;
              cmd_o.dir_wr  = 1'b1;
              cmd_o.cnt_clr = 1'b1;
              state_d       = ST_ZERO;
            end
          end
          OP_UNMAP: begin
            cmd_o.tbl_wr    = !status_i.link_zero;
            cmd_o.tdata_sel = TD_ZERO;
            fin             = 1'b1;
          end
          OP_LOOKUP: begin
            if (status_i.link_zero) begin
              fin = 1'b1;
            end else begin
              state_d = ST_TBL_RD;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      ST_ZERO: begin
        // clear new table, dropping the mapped entry in on the way
        cmd_o.tbl_wr    = 1'b1;
        cmd_o.taddr_sel = TA_WALK;
        cmd_o.tdata_sel = TD_WALK;
        cmd_o.cnt_inc   = 1'b1;
        fin             = status_i.cnt_last;
      end
      ST_TBL_RD: begin
        fin     = 1'b1;
        fin_sel = RES_LOOKUP;
      end
      ST_RESP: begin
        fin     = 1'b1;
        fin_sel = RES_HELD;
      end
      default: state_d = ST_IDLE;
    endcase

    if (fin) begin
      cmd_o.res_sel = fin_sel;
      if (status_i.out_free) begin
        cmd_o.load_out = 1'b1;
        state_d        = ST_IDLE;
      end else begin
        cmd_o.cap_res = (state_q != ST_RESP);
        state_d       = ST_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ===== rtl/two_level_page_table_manager.sv =====
// channel   dir  beat contents (tdata, lowest bit first)
// s_axis    in   operation[1:0] virtual_address[33:2] physical_address[65:34] page_flags[77:66]
// m_axis    out  hit[0] frame_address[32:1] table_full[33]
//
// a map, unmap or refused map beat goes through capture, then directory read
// lookup of a present table goes through capture, directory read, table read
// a map that allocates a table adds a clear walk over all 1024 table entries on the table memory port
// after reset all 1024 directory entries are cleared with s_axis_tready low
// results sit in an output register, so one new beat is taken while m_axis stalls; its result is then held
module two_level_page_table_manager import ptm_pkg::*; #(
  parameter int unsigned NUM_TABLES = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // operation, virtual_address, physical_address, page_flags
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // hit, frame_address, table_full
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  ptm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ptm_datapath #(
    .NUM_TABLES(NUM_TABLES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .out_ready_i(m_axis_tready),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ===== rtl/ptm_checker.sv =====
module ptm_checker import ptm_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0] pending_q, pending_d;
  logic       in_beat, out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pending_d = pending_q;
    if (in_beat && !out_beat) begin
      pending_d = pending_q + 2'd1;
    end else if (out_beat && !in_beat) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 2'd0)
    else $error("result beat without an accepted item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> pending_q != 2'd2)
    else $error("more than two items in flight");

  a_hit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[33])
    else $error("hit and table_full together");

  a_frame_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[32:1] != '0) |-> m_axis_tdata[0])
    else $error("frame address without hit");

endmodule

bind two_level_page_table_manager ptm_checker u_ptm_checker (.*);
